/* design/rvd_pkg.sv */
// Shared types, constants and helper functions for the ripple vertex displacement block.
package rvd_pkg;

    localparam int GRID_COLS        = 64;
    localparam int GRID_ROWS        = 64;
    localparam int AMPLITUDE_CHANGE = 0;

    localparam logic [10:0] GRID_COLS_LIM = 11'(GRID_COLS);
    localparam logic [10:0] GRID_ROWS_LIM = 11'(GRID_ROWS);
    localparam logic [31:0] AMP_CHG_MAG   =
        32'(AMPLITUDE_CHANGE < 0 ? -AMPLITUDE_CHANGE : AMPLITUDE_CHANGE);
    localparam logic        AMP_CHG_NEG   = (AMPLITUDE_CHANGE < 0);

    localparam logic [31:0] PHASE_K    = 32'd68356528;
    localparam logic [31:0] SIN_A      = 32'd1686629713;
    localparam logic [31:0] SIN_B      = 32'd693598668;
    localparam logic [31:0] SIN_C      = 32'd80710779;
    localparam logic [31:0] ONE30      = 32'h4000_0000;
    localparam logic [30:0] MAX_RADIUS = 31'h7FFF_FFFF;

    localparam logic [3:0] REG_CENTER_X       = 4'd0;
    localparam logic [3:0] REG_CENTER_Y       = 4'd1;
    localparam logic [3:0] REG_DRIFT_X        = 4'd2;
    localparam logic [3:0] REG_DRIFT_Y        = 4'd3;
    localparam logic [3:0] REG_BASE_RADIUS    = 4'd4;
    localparam logic [3:0] REG_RADIUS_CHANGE  = 4'd5;
    localparam logic [3:0] REG_BASE_AMPLITUDE = 4'd6;
    localparam logic [3:0] REG_WAVE_COUNT     = 4'd7;

    typedef struct packed {
        logic [6:0]         col;
        logic [6:0]         row;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
        logic [15:0]        time_fraction;
        logic [15:0]        amp_rate;
        logic               frame_end;
    } t_in_item;

    typedef struct packed {
        logic [6:0]         out_col;
        logic [6:0]         out_row;
        logic signed [31:0] displaced_z;
        logic               frame_done;
    } t_out_item;

    typedef struct packed {
        t_in_item item;
        logic     on_grid;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [4:0] {
        B_IDLE, B_CHK, B_SQX, B_SQY, B_SQRT, B_LEN, B_DIV, B_RATE,
        B_PH1, B_PH2, B_U2, B_S1, B_S2, B_S3, B_P1, B_P2, B_P3, B_Z,
        B_FE, B_FX, B_FY, B_FR, B_FA, B_DONE
    } t_bstate;

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        mag32 = x[31] ? (32'd0 - 32'(x)) : 32'(x);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sd2147483647) begin
            sat32 = 32'h7FFF_FFFF;
        end else if (v < -35'sd2147483648) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

/* design/rvd_queue.sv */
// Two-entry job queue between the front and back parts.
module rvd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rvd_pkg::t_job i_job,
    input  logic          i_pop,
    output rvd_pkg::t_job o_job,
    output rvd_pkg::t_q_stat o_stat
);
    rvd_pkg::t_job r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign do_push = i_push && (r_cnt != 2'd2);
    assign do_pop  = i_pop && (r_cnt != 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule

/* design/rvd_front.sv */
// Front part: accepts vertices, classifies grid position, feeds the queue.
module rvd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  rvd_pkg::t_in_item i_item,
    input  rvd_pkg::t_q_stat  i_q_stat,
    output logic              o_push,
    output rvd_pkg::t_job     o_job
);
    logic          r_valid;
    rvd_pkg::t_job r_job;
    logic          accept;

    assign o_push  = r_valid && !i_q_stat.full;
    assign o_stall = r_valid && i_q_stat.full;
    assign accept  = i_valid && !o_stall;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept || (r_valid && !o_push);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job.item    <= i_item;
            r_job.on_grid <= ({4'd0, i_item.col} <= rvd_pkg::GRID_COLS_LIM)
                          && ({4'd0, i_item.row} <= rvd_pkg::GRID_ROWS_LIM);
        end
    end
endmodule

/* design/rvd_back.sv */
// Back part: sequencer with shared multiplier, square root, divider and sine steps.
module rvd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rvd_pkg::t_q_stat   i_q_stat,
    input  rvd_pkg::t_job      i_job,
    output logic               o_pop,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output rvd_pkg::t_out_item o_item
);
    rvd_pkg::t_bstate r_state, n_state;

    logic signed [31:0] r_center_x, r_center_y, r_drift_x, r_drift_y;
    logic [30:0]        r_base_radius;
    logic signed [31:0] r_radius_change, r_base_amplitude;
    logic [15:0]        r_wave_count;
    logic signed [31:0] r_cx, r_cy, r_amp;
    logic [30:0]        r_rad;

    rvd_pkg::t_job r_job;
    logic [32:0]   r_adx, r_ady;
    logic [63:0]   r_acc, r_res;
    logic [4:0]    r_cnt;
    logic [30:0]   r_len, r_q, r_rate, r_u, r_u2;
    logic [32:0]   r_rem;
    logic [31:0]   r_ph, r_s, r_z;
    logic [32:0]   r_m;
    logic          r_neg, r_sneg;
    logic          r_ovalid;
    rvd_pkg::t_out_item r_out;

    logic signed [32:0] dx, dy;
    logic [32:0] adx, ady;
    logic        in_range;
    logic [63:0] bitv, trial;
    logic        sq_ge, div_ge, short_d;
    logic [32:0] div_diff;
    logic [30:0] u_val;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [33:0] s3;
    logic [32:0] fv;
    logic signed [34:0] zsum, fsum;
    logic        load_out;

    assign dx  = 33'(r_cx) - 33'(r_job.item.vertex_x);
    assign dy  = 33'(r_cy) - 33'(r_job.item.vertex_y);
    assign adx = dx[32] ? (33'd0 - 33'(dx)) : 33'(dx);
    assign ady = dy[32] ? (33'd0 - 33'(dy)) : 33'(dy);
    assign in_range = r_job.on_grid && (r_rad != 31'd0)
                   && (adx < {2'd0, r_rad}) && (ady < {2'd0, r_rad});

    assign bitv  = 64'd1 << {r_cnt, 1'b0};
    assign trial = r_res + bitv;
    assign sq_ge = (r_acc >= trial);
    assign short_d = (r_res[31:0] < {1'b0, r_rad});

    assign div_ge   = (r_rem >= {2'd0, r_rad});
    assign div_diff = div_ge ? (r_rem - {2'd0, r_rad}) : r_rem;

    assign u_val = r_ph[30] ? (31'(rvd_pkg::ONE30) - {1'b0, r_ph[29:0]})
                            : {1'b0, r_ph[29:0]};

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (r_state)
            rvd_pkg::B_SQX: begin
                mul_a = r_adx[31:0];
                mul_b = r_adx[31:0];
            end
            rvd_pkg::B_SQY: begin
                mul_a = r_ady[31:0];
                mul_b = r_ady[31:0];
            end
            rvd_pkg::B_RATE: begin
                mul_a = {1'b0, r_q};
                mul_b = {1'b0, r_q};
            end
            rvd_pkg::B_PH1: begin
                mul_a = {16'd0, r_wave_count};
                mul_b = {16'd0, r_job.item.time_fraction};
            end
            rvd_pkg::B_PH2: begin
                mul_a = {1'b0, r_len};
                mul_b = rvd_pkg::PHASE_K;
            end
            rvd_pkg::B_U2: begin
                mul_a = {1'b0, u_val};
                mul_b = {1'b0, u_val};
            end
            rvd_pkg::B_S1: begin
                mul_a = {1'b0, r_u2};
                mul_b = rvd_pkg::SIN_C;
            end
            rvd_pkg::B_S2: begin
                mul_a = {1'b0, r_u2};
                mul_b = r_s;
            end
            rvd_pkg::B_S3: begin
                mul_a = {1'b0, r_u};
                mul_b = r_s;
            end
            rvd_pkg::B_P1: begin
                mul_a = rvd_pkg::mag32(r_amp);
                mul_b = r_s;
            end
            rvd_pkg::B_P2: begin
                mul_a = r_m[31:0];
                mul_b = {1'b0, r_rate};
            end
            rvd_pkg::B_P3: begin
                mul_a = r_m[31:0];
                mul_b = {16'd0, r_job.item.amp_rate};
            end
            rvd_pkg::B_FX: begin
                mul_a = rvd_pkg::mag32(r_drift_x);
                mul_b = {16'd0, r_job.item.time_fraction};
            end
            rvd_pkg::B_FY: begin
                mul_a = rvd_pkg::mag32(r_drift_y);
                mul_b = {16'd0, r_job.item.time_fraction};
            end
            rvd_pkg::B_FR: begin
                mul_a = rvd_pkg::mag32(r_radius_change);
                mul_b = {16'd0, r_job.item.time_fraction};
            end
            rvd_pkg::B_FA: begin
                mul_a = rvd_pkg::AMP_CHG_MAG;
                mul_b = {16'd0, r_job.item.time_fraction};
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign s3    = mul_p[63:30];
    assign fv    = mul_p[47:15];
    assign zsum  = 35'(r_job.item.vertex_z) + (r_neg ? -35'(r_m) : 35'(r_m));

    always_comb begin
        fsum = 35'sd0;
        case (r_state)
            rvd_pkg::B_FX: fsum = 35'(r_center_x) + (r_drift_x[31] ? -35'(fv) : 35'(fv));
            rvd_pkg::B_FY: fsum = 35'(r_center_y) + (r_drift_y[31] ? -35'(fv) : 35'(fv));
            rvd_pkg::B_FR: fsum = 35'({1'b0, r_base_radius})
                       + (r_radius_change[31] ? -35'(fv) : 35'(fv));
            rvd_pkg::B_FA: fsum = 35'(r_base_amplitude)
                       + (rvd_pkg::AMP_CHG_NEG ? -35'(fv) : 35'(fv));
            default: fsum = 35'sd0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rvd_pkg::B_IDLE: if (!i_q_stat.empty) n_state = rvd_pkg::B_CHK;
            rvd_pkg::B_CHK:  n_state = in_range ? rvd_pkg::B_SQX : rvd_pkg::B_FE;
            rvd_pkg::B_SQX:  n_state = rvd_pkg::B_SQY;
            rvd_pkg::B_SQY:  n_state = rvd_pkg::B_SQRT;
            rvd_pkg::B_SQRT: if (r_cnt == 5'd0) n_state = rvd_pkg::B_LEN;
            rvd_pkg::B_LEN:  n_state = short_d ? rvd_pkg::B_DIV : rvd_pkg::B_FE;
            rvd_pkg::B_DIV:  if (r_cnt == 5'd0) n_state = rvd_pkg::B_RATE;
            rvd_pkg::B_RATE: n_state = rvd_pkg::B_PH1;
            rvd_pkg::B_PH1:  n_state = rvd_pkg::B_PH2;
            rvd_pkg::B_PH2:  n_state = rvd_pkg::B_U2;
            rvd_pkg::B_U2:   n_state = rvd_pkg::B_S1;
            rvd_pkg::B_S1:   n_state = rvd_pkg::B_S2;
            rvd_pkg::B_S2:   n_state = rvd_pkg::B_S3;
            rvd_pkg::B_S3:   n_state = rvd_pkg::B_P1;
            rvd_pkg::B_P1:   n_state = rvd_pkg::B_P2;
            rvd_pkg::B_P2:   n_state = rvd_pkg::B_P3;
            rvd_pkg::B_P3:   n_state = rvd_pkg::B_Z;
            rvd_pkg::B_Z:    n_state = rvd_pkg::B_FE;
            rvd_pkg::B_FE:   n_state = r_job.item.frame_end ? rvd_pkg::B_FX : rvd_pkg::B_DONE;
            rvd_pkg::B_FX:   n_state = rvd_pkg::B_FY;
            rvd_pkg::B_FY:   n_state = rvd_pkg::B_FR;
            rvd_pkg::B_FR:   n_state = rvd_pkg::B_FA;
            rvd_pkg::B_FA:   n_state = rvd_pkg::B_DONE;
            rvd_pkg::B_DONE: if (!r_ovalid || !i_stall) n_state = rvd_pkg::B_IDLE;
            default: n_state = rvd_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            rvd_pkg::B_IDLE: o_pop = !i_q_stat.empty;
            rvd_pkg::B_DONE: load_out = !r_ovalid || !i_stall;
            default: begin
                o_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rvd_pkg::B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.out_col     <= r_job.item.col;
            r_out.out_row     <= r_job.item.row;
            r_out.displaced_z <= r_z;
            r_out.frame_done  <= r_job.item.frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rvd_pkg::B_IDLE: begin
                r_job <= i_job;
            end
            rvd_pkg::B_CHK: begin
                r_adx <= adx;
                r_ady <= ady;
                r_z   <= r_job.item.vertex_z;
            end
            rvd_pkg::B_SQX: r_acc <= mul_p;
            rvd_pkg::B_SQY: begin
                r_acc <= r_acc + mul_p;
                r_res <= 64'd0;
                r_cnt <= 5'd31;
            end
            rvd_pkg::B_SQRT: begin
                if (sq_ge) begin
                    r_acc <= r_acc - trial;
                    r_res <= (r_res >> 1) + bitv;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_cnt <= r_cnt - 5'd1;
            end
            rvd_pkg::B_LEN: begin
                r_len <= r_rad - r_res[30:0];
                r_rem <= {2'd0, r_rad - r_res[30:0]};
                r_q   <= 31'd0;
                r_cnt <= 5'd30;
            end
            rvd_pkg::B_DIV: begin
                r_rem <= {div_diff[31:0], 1'b0};
                r_q   <= {r_q[29:0], div_ge};
                r_cnt <= r_cnt - 5'd1;
            end
            rvd_pkg::B_RATE: r_rate <= mul_p[60:30];
            rvd_pkg::B_PH1:  r_ph <= {mul_p[22:0], 9'd0};
            rvd_pkg::B_PH2:  r_ph <= r_ph + mul_p[47:16];
            rvd_pkg::B_U2: begin
                r_u    <= u_val;
                r_u2   <= mul_p[60:30];
                r_sneg <= r_ph[31];
            end
            rvd_pkg::B_S1: r_s <= rvd_pkg::SIN_B - mul_p[61:30];
            rvd_pkg::B_S2: r_s <= rvd_pkg::SIN_A - mul_p[61:30];
            rvd_pkg::B_S3: r_s <= (s3 > {2'd0, rvd_pkg::ONE30}) ? rvd_pkg::ONE30 : s3[31:0];
            rvd_pkg::B_P1: begin
                r_m   <= {1'b0, mul_p[61:30]};
                r_neg <= r_amp[31] ^ r_sneg;
            end
            rvd_pkg::B_P2: r_m <= {1'b0, mul_p[61:30]};
            rvd_pkg::B_P3: r_m <= mul_p[47:15];
            rvd_pkg::B_Z:  r_z <= rvd_pkg::sat32(zsum);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x       <= 32'sd0;
            r_center_y       <= 32'sd0;
            r_drift_x        <= 32'sd0;
            r_drift_y        <= 32'sd0;
            r_base_radius    <= 31'd0;
            r_radius_change  <= 32'sd0;
            r_base_amplitude <= 32'sd0;
            r_wave_count     <= 16'd256;
            r_cx             <= 32'sd0;
            r_cy             <= 32'sd0;
            r_rad            <= 31'd0;
            r_amp            <= 32'sd0;
        end else begin
            case (r_state)
                rvd_pkg::B_FX: r_cx <= rvd_pkg::sat32(fsum);
                rvd_pkg::B_FY: r_cy <= rvd_pkg::sat32(fsum);
                rvd_pkg::B_FR: begin
                    if (fsum < 35'sd0) begin
                        r_rad <= 31'd0;
                    end else if (fsum > 35'(rvd_pkg::MAX_RADIUS)) begin
                        r_rad <= rvd_pkg::MAX_RADIUS;
                    end else begin
                        r_rad <= fsum[30:0];
                    end
                end
                rvd_pkg::B_FA: r_amp <= rvd_pkg::sat32(fsum);
                default: begin
                end
            endcase
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rvd_pkg::REG_CENTER_X: begin
                        r_center_x <= i_cfg_data;
                        r_cx       <= i_cfg_data;
                    end
                    rvd_pkg::REG_CENTER_Y: begin
                        r_center_y <= i_cfg_data;
                        r_cy       <= i_cfg_data;
                    end
                    rvd_pkg::REG_DRIFT_X: r_drift_x <= i_cfg_data;
                    rvd_pkg::REG_DRIFT_Y: r_drift_y <= i_cfg_data;
                    rvd_pkg::REG_BASE_RADIUS: begin
                        r_base_radius <= i_cfg_data[30:0];
                        r_rad         <= i_cfg_data[30:0];
                    end
                    rvd_pkg::REG_RADIUS_CHANGE: r_radius_change <= i_cfg_data;
                    rvd_pkg::REG_BASE_AMPLITUDE: begin
                        r_base_amplitude <= i_cfg_data;
                        r_amp            <= i_cfg_data;
                    end
                    rvd_pkg::REG_WAVE_COUNT: r_wave_count <= i_cfg_data[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_out;
endmodule

/* design/ripple_vertex_displacement.sv */
// Top level of the ripple vertex displacement block: front, queue and back.
// A vertex inside the ripple runs through a 32-step square root, a 31-step divider and 12
// multiplier steps; one inside the bounding box but beyond the radius stops after the square
// root; one outside the box or off the grid skips both; a frame end adds the ripple updates.
// The shared sequencer works on one vertex at a time; the front and queue take more meanwhile.
// Reset: synchronous active-low i_rst_n clears control, config and ripple state.
module ripple_vertex_displacement (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rvd_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output rvd_pkg::t_out_item o_item,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    rvd_pkg::t_q_stat q_stat;
    rvd_pkg::t_job    f_job, q_job;
    logic             push, pop;

    rvd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_item   (i_item),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_job    (f_job)
    );

    rvd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    rvd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (q_stat),
        .i_job      (q_job),
        .o_pop      (pop),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_stat.full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && q_stat.empty))
        else $error("queue pop while empty");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
endmodule

/* sim/rvd_checker.sv */
// Checker for the ripple vertex displacement block: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module rvd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  rvd_pkg::t_in_item  i_item,
    input  logic               i_valid_out,
    input  logic               i_stall_out,
    input  rvd_pkg::t_out_item i_result,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);
    longint m_center_x, m_center_y, m_drift_x, m_drift_y;
    longint m_base_radius, m_radius_change, m_base_amp;
    longint m_waves;
    longint s_cx, s_cy, s_radius, s_amp;
    rvd_pkg::t_out_item z_expected[$];

    function automatic longint sx32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint mul_trunc(longint a, longint b, int sh);
        logic [63:0] ma, mb, m;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        m = (ma * mb) >> sh;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint sine_turns(logic [31:0] ph);
        longint u, u2, s;
        u = longint'(ph[29:0]);
        if (ph[30]) u = (64'sd1 << 30) - u;
        u2 = (u * u) >>> 30;
        s = longint'(rvd_pkg::SIN_B) - ((u2 * longint'(rvd_pkg::SIN_C)) >>> 30);
        s = longint'(rvd_pkg::SIN_A) - ((u2 * s) >>> 30);
        s = (u * s) >>> 30;
        if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
        if (s < 0) s = 0;
        return ph[31] ? -s : s;
    endfunction

    function automatic rvd_pkg::t_out_item displace(rvd_pkg::t_in_item it);
        rvd_pkg::t_out_item r;
        longint z, adx, ady, d, len, q, fall, p;
        logic [63:0] ph;
        z = sx32(it.vertex_z);
        if (it.col <= rvd_pkg::GRID_COLS && it.row <= rvd_pkg::GRID_ROWS && s_radius > 0) begin
            adx = s_cx - sx32(it.vertex_x);
            ady = s_cy - sx32(it.vertex_y);
            if (adx < 0) adx = -adx;
            if (ady < 0) ady = -ady;
            if (adx < s_radius && ady < s_radius) begin
                d = longint'(root_floor(64'(adx * adx) + 64'(ady * ady)));
                if (d < s_radius) begin
                    len = s_radius - d;
                    q = (len << 30) / s_radius;
                    fall = (q * q) >>> 30;
                    ph = ((64'(m_waves) * 64'(it.time_fraction)) << 9)
                       + ((64'(len) * 64'(rvd_pkg::PHASE_K)) >> 16);
                    p = mul_trunc(s_amp, sine_turns(ph[31:0]), 30);
                    p = mul_trunc(p, fall, 30);
                    p = mul_trunc(p, longint'(it.amp_rate), 15);
                    z = clip32(z + p);
                end
            end
        end
        if (it.frame_end) begin
            longint t, rr;
            t = longint'(it.time_fraction);
            s_cx = clip32(m_center_x + mul_trunc(m_drift_x, t, 15));
            s_cy = clip32(m_center_y + mul_trunc(m_drift_y, t, 15));
            s_amp = clip32(m_base_amp
                           + mul_trunc(longint'(rvd_pkg::AMPLITUDE_CHANGE), t, 15));
            rr = m_base_radius + mul_trunc(m_radius_change, t, 15);
            if (rr < 0) rr = 0;
            if (rr > 64'sd2147483647) rr = 64'sd2147483647;
            s_radius = rr;
        end
        r.out_col = it.col;
        r.out_row = it.row;
        r.displaced_z = z[31:0];
        r.frame_done = it.frame_end;
        return r;
    endfunction

    assign o_pending = z_expected.size();

    always @(posedge i_clk) begin
        rvd_pkg::t_out_item e;
        if (!i_rst_n) begin
            m_center_x <= 0; m_center_y <= 0; m_drift_x <= 0; m_drift_y <= 0;
            m_base_radius <= 0; m_radius_change <= 0; m_base_amp <= 0;
            m_waves <= 256;
            s_cx <= 0; s_cy <= 0; s_radius <= 0; s_amp <= 0;
            o_errors <= 0;
            z_expected.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rvd_pkg::REG_CENTER_X: begin
                        m_center_x = sx32(i_cfg_data); s_cx = m_center_x;
                    end
                    rvd_pkg::REG_CENTER_Y: begin
                        m_center_y = sx32(i_cfg_data); s_cy = m_center_y;
                    end
                    rvd_pkg::REG_DRIFT_X: m_drift_x = sx32(i_cfg_data);
                    rvd_pkg::REG_DRIFT_Y: m_drift_y = sx32(i_cfg_data);
                    rvd_pkg::REG_BASE_RADIUS: begin
                        m_base_radius = longint'(i_cfg_data[30:0]);
                        s_radius = m_base_radius;
                    end
                    rvd_pkg::REG_RADIUS_CHANGE: m_radius_change = sx32(i_cfg_data);
                    rvd_pkg::REG_BASE_AMPLITUDE: begin
                        m_base_amp = sx32(i_cfg_data); s_amp = m_base_amp;
                    end
                    rvd_pkg::REG_WAVE_COUNT: m_waves = longint'(i_cfg_data[15:0]);
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in) z_expected.push_back(displace(i_item));
            if (i_valid_out && !i_stall_out) begin
                if (z_expected.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result %p", i_result);
                    o_errors <= o_errors + 1;
                end else begin
                    e = z_expected.pop_front();
                    if (e !== i_result) begin
                        if (o_errors < 10) $display("mismatch: expected %p actual %p", e, i_result);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

/* sim/tb_ripple_vertex_displacement.sv */
// Testbench top for the ripple vertex displacement block: stimulus, configuration and verdict.
`timescale 1ns / 100ps
module tb_ripple_vertex_displacement;
    localparam int WATCHDOG = 20000;

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, o_stall, o_valid, i_stall = 1;
    rvd_pkg::t_in_item i_item = '0;
    rvd_pkg::t_out_item o_item;
    logic i_cfg_we = 0;
    logic [3:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    int errors, pending;
    int idle_cycles = 0;
    bit stim_done = 0, hold_long = 0;
    int cx, cy, rad;

    always #6 i_clk = ~i_clk;

    ripple_vertex_displacement dut (.*);

    rvd_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_item(i_item), .i_valid_out(o_valid), .i_stall_out(i_stall), .i_result(o_item),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("tb_ripple_vertex_displacement: errors");
            $finish;
        end
    end

    // receiver: random stall per transfer, one long hold-off on request
    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                i_stall <= 1;
                repeat (600) @(negedge i_clk);
                hold_long = 0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (w > 0) begin
                i_stall <= 1;
                repeat (w) @(negedge i_clk);
            end
            i_stall <= 0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic cfg_write(input logic [3:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain;
        while (pending != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic send_vertex(input rvd_pkg::t_in_item it, input bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 10) : 0;
        if (w > 0) begin
            @(negedge i_clk);
            i_valid <= 0;
            repeat (w - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1; i_item <= it;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic stop_sending;
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    function automatic logic [31:0] near(int c, int spread);
        return 32'(c + $signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic rvd_pkg::t_in_item rand_vertex(int c_x, int c_y, int r, bit wild);
        rvd_pkg::t_in_item it;
        it.col = wild ? 7'($urandom) : 7'($urandom_range(0, 64));
        it.row = wild ? 7'($urandom) : 7'($urandom_range(0, 64));
        if (wild || r == 0) begin
            it.vertex_x = $urandom; it.vertex_y = $urandom;
        end else begin
            it.vertex_x = near(c_x, r); it.vertex_y = near(c_y, r);
        end
        it.vertex_z = ($urandom_range(0, 7) == 0)
                    ? {$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'($urandom)}
                    : $urandom;
        it.time_fraction = wild ? 16'($urandom) : 16'($urandom_range(0, 32768));
        it.amp_rate = wild ? 16'($urandom) : 16'($urandom_range(0, 32768));
        it.frame_end = ($urandom_range(0, 7) == 0);
        return it;
    endfunction

    task automatic setup(input int c_x, input int c_y, input int r, input logic [31:0] amp,
                         input logic [15:0] waves);
        cfg_write(rvd_pkg::REG_CENTER_X, c_x);
        cfg_write(rvd_pkg::REG_CENTER_Y, c_y);
        cfg_write(rvd_pkg::REG_DRIFT_X,
                  $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4096));
        cfg_write(rvd_pkg::REG_DRIFT_Y,
                  $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4096));
        cfg_write(rvd_pkg::REG_BASE_RADIUS, r);
        cfg_write(rvd_pkg::REG_RADIUS_CHANGE,
                  $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 8192)) - 4096);
        cfg_write(rvd_pkg::REG_BASE_AMPLITUDE, amp);
        cfg_write(rvd_pkg::REG_WAVE_COUNT, waves);
        cfg_write(4'd15, $urandom);
    endtask

    initial begin
        rvd_pkg::t_in_item it;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, outside, zero radius, off grid, frame ends
        setup(0, 0, 32'h0004_0000, 32'h0010_0000, 16'd256);
        cx = 0; cy = 0; rad = 32'h0004_0000;
        for (int k = 0; k < 22; k++) begin
            it = rand_vertex(cx, cy, rad, 0);
            case (k)
                0: begin it.vertex_x = 0; it.vertex_y = 0; it.amp_rate = 16'hFFFF; end
                1: begin it.vertex_x = 32'h7FFF_FFFF; it.vertex_y = 32'h8000_0000; end
                2: begin it.col = 7'h7F; it.row = 0; end
                3: begin it.col = 64; it.row = 64; it.vertex_x = 1; end
                4: begin it.row = 65; end
                5: begin it.vertex_z = 32'h7FFF_FFF0; it.amp_rate = 16'h8000; end
                6: begin it.vertex_z = 32'h8000_0010; it.time_fraction = 16'hFFFF; end
                7: begin it.frame_end = 1; it.time_fraction = 16'hFFFF; end
                8: begin it.frame_end = 1; it.time_fraction = 0; end
                9: begin it.vertex_x = 32'h0003_FFFF; it.vertex_y = 0; end
                default: ;
            endcase
            send_vertex(it, k > 12);
        end
        stop_sending();
        drain();
        setup(0, 0, 0, 32'h7FFF_FFFF, 16'hFFFF);
        for (int k = 0; k < 3; k++) send_vertex(rand_vertex(0, 0, 0, 0), 0);
        stop_sending();
        drain();

        // random phases, several settings including extremes
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin cx = 32'h7FFF_0000; cy = 32'h8000_0000; rad = 32'h7FFF_FFFF; end
                1: begin cx = 0; cy = 0; rad = 1; end
                default: begin
                    cx = $urandom; cy = $urandom;
                    rad = $urandom_range(0, 1) ? $urandom_range(1, 32'h0100_0000)
                                               : $urandom_range(1, 32'h7FFF_FFFF);
                end
            endcase
            setup(cx, cy, rad,
                  ph == 0 ? 32'h8000_0000 : ph == 1 ? 32'h7FFF_FFFF : $urandom,
                  ph == 0 ? 16'hFFFF : ph == 1 ? 16'h0000 : 16'($urandom));
            if (ph == 3) hold_long = 1;
            for (int k = 0; k < 72; k++)
                send_vertex(rand_vertex(cx, cy, rad, $urandom_range(0, 9) == 0),
                            (k % 24) < 16);
            stop_sending();
            drain();
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (errors == 0) $display("tb_ripple_vertex_displacement: clean");
        else $display("tb_ripple_vertex_displacement: errors");
        $finish;
    end
endmodule
